[rtl/core/lru_byte_budget_tracker_core_defines.svh]
// Assertion macros shared by the tracker RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef LRU_BYTE_BUDGET_TRACKER_CORE_DEFINES_SVH
`define LRU_BYTE_BUDGET_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define LBBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define LBBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/lbbt_pkg.sv]
// Shared types and constants of the LRU byte-budget tracker.
// No dependencies; used by the cell, the size readout tree and the top level.
`timescale 1ns / 1ps

package lbbt_pkg;

	localparam int KEY_W       = 64;
	localparam int SIZE_W      = 36;
	localparam int BUDGET_W    = 36;
	localparam int CAP_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 36;
	localparam int GROUP_SIZE  = 8;
	localparam int MAX_ENTRIES_DEF = 64;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 36'd67108864;
	localparam logic [CAP_W-1:0]    CAP_RESET    = 7'd64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_CAP   = 2'd1;

	typedef enum logic [1:0] {
		OP_TOUCH  = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// What every cell does with its contents this cycle
	typedef enum logic [1:0] {
		MODE_HOLD     = 2'd0,
		MODE_SHIFT    = 2'd1,
		MODE_ROT_FWD  = 2'd2,
		MODE_ROT_BACK = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t          mode;
		logic                load_en;
		logic                cmp_en;
		logic [KEY_W-1:0]    cmp_key;
		logic [KEY_W-1:0]    load_key;
		logic [SIZE_W-1:0]   load_size;
	} cell_ctl_t;

endpackage

[rtl/core/lbbt_cell.sv]
// One slot of the recency-ordered row: key, size and a registered match flag.
// Depends on lbbt_pkg. Lower index is more recent; the last cell is the oldest.
`timescale 1ns / 1ps

module lbbt_cell #(
	parameter int N   = lbbt_pkg::MAX_ENTRIES_DEF,
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lbbt_pkg::cell_ctl_t           ctl,
	input  logic [$clog2(N+1)-1:0]        head,
	input  logic [$clog2(N+1)-1:0]        load_slot,
	input  logic                          at_or_above,
	input  logic [lbbt_pkg::KEY_W-1:0]    left_key,
	input  logic [lbbt_pkg::SIZE_W-1:0]   left_size,
	input  logic [lbbt_pkg::KEY_W-1:0]    right_key,
	input  logic [lbbt_pkg::SIZE_W-1:0]   right_size,
	output logic [lbbt_pkg::KEY_W-1:0]    key,
	output logic [lbbt_pkg::SIZE_W-1:0]   size,
	output logic                          match
);

	localparam int CW = $clog2(N+1);
	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [lbbt_pkg::KEY_W-1:0]  key_q;
	logic [lbbt_pkg::SIZE_W-1:0] size_q;
	logic [lbbt_pkg::KEY_W-1:0]  key_d;
	logic [lbbt_pkg::SIZE_W-1:0] size_d;
	logic                        match_q;
	logic                        slot_valid;

	// Occupied cells are packed against the oldest end of the row
	assign slot_valid = (MY_IDX >= head);

	// Capture the key comparison when a word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_q <= slot_valid && (key_q == ctl.cmp_key);
		end
	end

	// Select next contents: hold, take a neighbour, or load a new entry
	always_comb begin
		key_d  = key_q;
		size_d = size_q;
		case (ctl.mode)
			lbbt_pkg::MODE_HOLD: begin
				key_d  = key_q;
				size_d = size_q;
			end
			lbbt_pkg::MODE_SHIFT: begin
				if ((MY_IDX > head) && at_or_above) begin
					key_d  = left_key;
					size_d = left_size;
				end
			end
			lbbt_pkg::MODE_ROT_FWD: begin
				key_d  = left_key;
				size_d = left_size;
			end
			lbbt_pkg::MODE_ROT_BACK: begin
				key_d  = right_key;
				size_d = right_size;
			end
			default: begin
				key_d  = key_q;
				size_d = size_q;
			end
		endcase
		if (ctl.load_en && (MY_IDX == load_slot)) begin
			key_d  = ctl.load_key;
			size_d = ctl.load_size;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_d;
		size_q <= size_d;
	end

	assign key   = key_q;
	assign size  = size_q;
	assign match = match_q;

endmodule

[rtl/core/lbbt_size_tree.sv]
// Registered one-hot readout of the size held by the matching cell.
// Depends on lbbt_pkg. Groups of GROUP_SIZE cells are folded and registered, then merged.
`timescale 1ns / 1ps

module lbbt_size_tree #(
	parameter int N = lbbt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic [N-1:0]                  match,
	input  logic [lbbt_pkg::SIZE_W-1:0]   sizes [N],
	output logic [lbbt_pkg::SIZE_W-1:0]   sel
);

	localparam int G  = lbbt_pkg::GROUP_SIZE;
	localparam int NG = (N + G - 1) / G;

	logic [lbbt_pkg::SIZE_W-1:0] grp_d  [NG];
	logic [lbbt_pkg::SIZE_W-1:0] grp_s1 [NG];

	// Fold each group of cells
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < G; k++) begin
				if (g * G + k < N) begin
					if (match[g * G + k]) begin
						grp_d[g] = grp_d[g] | sizes[g * G + k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	// Merge the group results
	always_comb begin
		sel = '0;
		for (int g = 0; g < NG; g++) begin
			sel = sel | grp_s1[g];
		end
	end

endmodule

[rtl/core/lru_byte_budget_tracker_core.sv]
// Top level of the LRU byte-budget tracker: control, totals and the cell row.
// Depends on lbbt_pkg, lbbt_cell, lbbt_size_tree and the assertion macro header.
`timescale 1ns / 1ps
`include "lru_byte_budget_tracker_core_defines.svh"

// A word is taken when start is high and busy is low. Touch, insert and remove
// match the key in every cell, then fold the matching cell's size through the
// registered group tree, then update the row, and only then take the next word;
// their single result appears, strobed by result_valid, in the cycle after the
// update. A victims query keeps busy high while the row rotates one place per
// cycle so that each victim passes the oldest cell and is emitted, and while it
// then rotates back as many places. Results come one per cycle and must be taken
// as they appear; the receiver cannot stall. Configuration must be written by the
// user only while idle; the block itself does not enforce this.
module lru_byte_budget_tracker_core #(
	parameter int MAX_ENTRIES = lbbt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic [lbbt_pkg::KEY_W-1:0]        key,
	input  logic [lbbt_pkg::SIZE_W-1:0]       entry_bytes,
	input  logic                              cfg_we,
	input  logic [lbbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lbbt_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              result_valid,
	output logic [1:0]                        status,
	output logic                              victim_valid,
	output logic [lbbt_pkg::KEY_W-1:0]        victim_key,
	output logic [lbbt_pkg::SIZE_W-1:0]       freed_bytes,
	output logic                              last
);

	localparam int N  = MAX_ENTRIES;
	localparam int CW = $clog2(N + 1);
	localparam int TW = lbbt_pkg::SIZE_W + $clog2(N);
	localparam int DW = TW + 2;
	localparam int KW = (CW > lbbt_pkg::CAP_W) ? CW : lbbt_pkg::CAP_W;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_SEL     = 5'b00010,
		S_APPLY   = 5'b00100,
		S_QUERY   = 5'b01000,
		S_RESTORE = 5'b10000
	} state_t;

	state_t                          state_q;
	lbbt_pkg::op_t                   op_q;
	logic [lbbt_pkg::KEY_W-1:0]      key_q;
	logic [lbbt_pkg::SIZE_W-1:0]     bytes_q;
	logic [CW-1:0]                   count_q;
	logic [TW-1:0]                   total_q;
	logic [lbbt_pkg::BUDGET_W-1:0]   budget_q;
	logic [lbbt_pkg::CAP_W-1:0]      cap_q;
	logic [CW-1:0]                   kept_q;
	logic [CW-1:0]                   n_q;
	logic signed [DW-1:0]            d_q;

	logic                            result_valid_q;
	lbbt_pkg::status_t               status_q;
	logic                            victim_valid_q;
	logic [lbbt_pkg::KEY_W-1:0]      victim_key_q;
	logic [lbbt_pkg::SIZE_W-1:0]     freed_q;
	logic                            last_q;

	lbbt_pkg::cell_ctl_t             ctl;
	logic [CW-1:0]                   head;
	logic [CW-1:0]                   load_slot;
	logic [N-1:0]                    match_vec;
	logic [N-1:0]                    at_or_above;
	logic [lbbt_pkg::KEY_W-1:0]      cell_key  [N];
	logic [lbbt_pkg::SIZE_W-1:0]     cell_size [N];
	logic [lbbt_pkg::SIZE_W-1:0]     size_sel;

	logic                            accept;
	logic                            hit;
	logic                            full;
	logic [lbbt_pkg::CAP_W-1:0]      cap_eff;
	logic signed [DW-1:0]            d_start;
	logic signed [DW-1:0]            tail_ext;
	logic                            d_le0;
	logic                            d_le_tail;
	logic                            kept_lt_cap;
	logic                            kept_le_cap;
	logic                            stop_now;
	logic                            last_victim;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign head   = CW'(N) - count_q;
	assign hit    = |match_vec;
	assign full   = (count_q == CW'(N));

	// Prefix of matches toward the oldest end marks the cells that shift
	for (genvar j = 0; j < N; j++) begin : g_prefix
		assign at_or_above[j] = |match_vec[N-1:j];
	end

	// Row of cells, each wired to its ring neighbours
	for (genvar i = 0; i < N; i++) begin : g_cell
		localparam int LEFT  = (i == 0) ? N - 1 : i - 1;
		localparam int RIGHT = (i == N - 1) ? 0 : i + 1;
		lbbt_cell #(
			.N   (N),
			.IDX (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.head        (head),
			.load_slot   (load_slot),
			.at_or_above (at_or_above[i]),
			.left_key    (cell_key[LEFT]),
			.left_size   (cell_size[LEFT]),
			.right_key   (cell_key[RIGHT]),
			.right_size  (cell_size[RIGHT]),
			.key         (cell_key[i]),
			.size        (cell_size[i]),
			.match       (match_vec[i])
		);
	end

	lbbt_size_tree #(
		.N (N)
	) u_size_tree (
		.clk   (clk),
		.match (match_vec),
		.sizes (cell_size),
		.sel   (size_sel)
	);

	// Victim walk terms; the remaining excess is kept as one signed difference
	assign cap_eff     = (cap_q == '0) ? lbbt_pkg::CAP_W'(1) : cap_q;
	assign d_start     = $signed(DW'(total_q)) - $signed(DW'(budget_q))
	                     + $signed(DW'(entry_bytes));
	assign tail_ext    = $signed(DW'(cell_size[N-1]));
	assign d_le0       = d_q[DW-1] || (d_q == '0);
	assign d_le_tail   = (d_q <= tail_ext);
	assign kept_lt_cap = (KW'(kept_q) < KW'(cap_eff));
	assign kept_le_cap = (KW'(kept_q) <= KW'(cap_eff));
	assign stop_now    = (kept_q == '0) || (d_le0 && kept_lt_cap);
	assign last_victim = (kept_q == CW'(1)) || (d_le_tail && kept_le_cap);

	// Drive the cell row
	always_comb begin
		ctl.mode      = lbbt_pkg::MODE_HOLD;
		ctl.load_en   = 1'b0;
		ctl.cmp_en    = accept;
		ctl.cmp_key   = key;
		ctl.load_key  = key_q;
		ctl.load_size = bytes_q;
		load_slot     = head;
		case (state_q)
			S_APPLY: begin
				case (op_q)
					lbbt_pkg::OP_TOUCH: begin
						if (hit) begin
							ctl.mode      = lbbt_pkg::MODE_SHIFT;
							ctl.load_en   = 1'b1;
							ctl.load_size = size_sel;
						end
					end
					lbbt_pkg::OP_INSERT: begin
						if (!hit && !full) begin
							ctl.load_en = 1'b1;
							load_slot   = head - CW'(1);
						end
					end
					lbbt_pkg::OP_REMOVE: begin
						if (hit) begin
							ctl.mode = lbbt_pkg::MODE_SHIFT;
						end
					end
					default: begin
						ctl.mode = lbbt_pkg::MODE_HOLD;
					end
				endcase
			end
			S_QUERY: begin
				if (!((n_q == '0) && stop_now)) begin
					ctl.mode = lbbt_pkg::MODE_ROT_FWD;
				end
			end
			S_RESTORE: begin
				ctl.mode = lbbt_pkg::MODE_ROT_BACK;
			end
			default: begin
				ctl.mode = lbbt_pkg::MODE_HOLD;
			end
		endcase
	end

	// Latch the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= lbbt_pkg::op_t'(operation);
			key_q   <= key;
			bytes_q <= entry_bytes;
		end
	end

	// Sequence control, totals, configuration and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			total_q        <= '0;
			budget_q       <= lbbt_pkg::BUDGET_RESET;
			cap_q          <= lbbt_pkg::CAP_RESET;
			kept_q         <= '0;
			n_q            <= '0;
			d_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					lbbt_pkg::REG_BYTE_BUDGET: budget_q <= cfg_data[lbbt_pkg::BUDGET_W-1:0];
					lbbt_pkg::REG_COUNT_CAP:   cap_q    <= cfg_data[lbbt_pkg::CAP_W-1:0];
					default: begin
						budget_q <= budget_q;
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (lbbt_pkg::op_t'(operation) == lbbt_pkg::OP_QUERY) begin
							state_q <= S_QUERY;
							kept_q  <= count_q;
							n_q     <= '0;
							d_q     <= d_start;
						end else begin
							state_q <= S_SEL;
						end
					end
				end
				S_SEL: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q        <= S_IDLE;
					result_valid_q <= 1'b1;
					case (op_q)
						lbbt_pkg::OP_INSERT: begin
							if (!hit && !full) begin
								count_q <= count_q + CW'(1);
								total_q <= total_q + TW'(bytes_q);
							end
						end
						lbbt_pkg::OP_REMOVE: begin
							if (hit) begin
								count_q <= count_q - CW'(1);
								total_q <= total_q - TW'(size_sel);
							end
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
				S_QUERY: begin
					result_valid_q <= 1'b1;
					if ((n_q == '0) && stop_now) begin
						state_q <= S_IDLE;
					end else begin
						kept_q <= kept_q - CW'(1);
						n_q    <= n_q + CW'(1);
						d_q    <= d_q - tail_ext;
						if (last_victim) begin
							state_q <= S_RESTORE;
						end
					end
				end
				S_RESTORE: begin
					n_q <= n_q - CW'(1);
					if (n_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) begin
			victim_valid_q <= 1'b0;
			victim_key_q   <= '0;
			freed_q        <= '0;
			last_q         <= 1'b1;
			case (op_q)
				lbbt_pkg::OP_TOUCH: begin
					status_q <= hit ? lbbt_pkg::ST_OK : lbbt_pkg::ST_NOT_FOUND;
				end
				lbbt_pkg::OP_INSERT: begin
					if (hit) begin
						status_q <= lbbt_pkg::ST_DUPLICATE;
					end else if (full) begin
						status_q <= lbbt_pkg::ST_FULL;
					end else begin
						status_q <= lbbt_pkg::ST_OK;
					end
				end
				lbbt_pkg::OP_REMOVE: begin
					status_q <= hit ? lbbt_pkg::ST_OK : lbbt_pkg::ST_NOT_FOUND;
					freed_q  <= hit ? size_sel : '0;
				end
				default: begin
					status_q <= lbbt_pkg::ST_OK;
				end
			endcase
		end else if (state_q == S_QUERY) begin
			status_q <= lbbt_pkg::ST_OK;
			freed_q  <= '0;
			if ((n_q == '0) && stop_now) begin
				victim_valid_q <= 1'b0;
				victim_key_q   <= '0;
				last_q         <= 1'b1;
			end else begin
				victim_valid_q <= 1'b1;
				victim_key_q   <= cell_key[N-1];
				last_q         <= last_victim;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign victim_valid = victim_valid_q;
	assign victim_key   = victim_key_q;
	assign freed_bytes  = freed_q;
	assign last         = last_q;

	// Checks on sequencing and bookkeeping
	`LBBT_ASSERT_NEXT(a_apply_result, clk, arst_n, state_q == S_APPLY, result_valid_q && last_q, "update gave no final result")
	`LBBT_ASSERT_IMPL(a_victim_status, clk, arst_n, result_valid_q && victim_valid_q, status_q == lbbt_pkg::ST_OK, "victim with bad status")
	`LBBT_ASSERT_NEXT(a_count_stable, clk, arst_n, state_q != S_APPLY, $stable(count_q), "entry count moved outside update")
	`LBBT_ASSERT_IMPL(a_restore_count, clk, arst_n, state_q == S_RESTORE, n_q != '0, "rotate back with nothing to undo")
	`LBBT_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "accepted word did not raise busy")

endmodule

[dv/lru_byte_budget_tracker_core_tb.sv]
// Self-checking testbench for lru_byte_budget_tracker_core: a directed table, then random phases.
// It keeps its own recency-ordered copy of the store to predict every result.
// Depends on lbbt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module lru_byte_budget_tracker_core_tb;
	import lbbt_pkg::*;

	localparam int STORE_DEPTH = MAX_ENTRIES_DEF;
	localparam int POOL_SIZE   = 96;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 56;

	// Register indexes that the block decodes to nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	localparam logic [KEY_W-1:0]  KEY_ZERO = '0;
	localparam logic [KEY_W-1:0]  KEY_ONES = '1;
	localparam logic [KEY_W-1:0]  KEY_MIX  = 64'hA5A5_5A5A_0F0F_F0F0;
	localparam logic [KEY_W-1:0]  KEY_SEQ  = 64'h0123_4567_89AB_CDEF;
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	typedef struct packed {
		status_t            status;
		logic               victim_valid;
		logic [KEY_W-1:0]   victim_key;
		logic [SIZE_W-1:0]  freed_bytes;
		logic               last;
	} outcome_t;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_val;
		op_t                   op;
		logic [KEY_W-1:0]      key;
		logic [SIZE_W-1:0]     bytes;
		logic                  typed;
		outcome_t              res;
	} step_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [1:0]             operation;
	logic [KEY_W-1:0]       key;
	logic [SIZE_W-1:0]      entry_bytes;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   result_valid;
	logic [1:0]             status;
	logic                   victim_valid;
	logic [KEY_W-1:0]       victim_key;
	logic [SIZE_W-1:0]      freed_bytes;
	logic                   last;

	// Predicted store: index 0 is the most recent entry
	logic [KEY_W-1:0]   lru_keys[$];
	logic [SIZE_W-1:0]  lru_sizes[$];
	logic [63:0]        held_bytes;
	logic [BUDGET_W-1:0] budget_now;
	logic [CAP_W-1:0]   cap_now;

	outcome_t           awaited[$];
	outcome_t           fresh[$];
	int                 mismatches;
	bit                 steady;
	logic [KEY_W-1:0]   key_pool[POOL_SIZE];
	step_t              plan[$];

	lru_byte_budget_tracker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.key          (key),
		.entry_bytes  (entry_bytes),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.status       (status),
		.victim_valid (victim_valid),
		.victim_key   (victim_key),
		.freed_bytes  (freed_bytes),
		.last         (last)
	);

	always #6 clk = ~clk;

	// Position of a key in the recency list, -1 if absent
	function automatic int locate(logic [KEY_W-1:0] k);
		for (int i = 0; i < lru_keys.size(); i++)
			if (lru_keys[i] == k)
				return i;
		return -1;
	endfunction

	// Apply one word to the predicted store and leave its results in fresh
	function automatic void track_word(op_t op, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] b);
		int idx;
		int kept;
		int unsigned cap_eff;
		logic [63:0] released;
		logic [SIZE_W-1:0] sz;
		outcome_t o;
		fresh.delete();
		o = '0;
		o.status = ST_OK;
		o.last = 1'b1;
		idx = locate(k);
		case (op)
		OP_TOUCH: begin
			if (idx < 0) begin
				o.status = ST_NOT_FOUND;
			end else begin
				sz = lru_sizes[idx];
				lru_keys.delete(idx);
				lru_sizes.delete(idx);
				lru_keys = {k, lru_keys};
				lru_sizes = {sz, lru_sizes};
			end
		end
		OP_INSERT: begin
			if (idx >= 0) begin
				o.status = ST_DUPLICATE;
			end else if (lru_keys.size() >= STORE_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				lru_keys = {k, lru_keys};
				lru_sizes = {b, lru_sizes};
				held_bytes += b;
			end
		end
		OP_REMOVE: begin
			if (idx < 0) begin
				o.status = ST_NOT_FOUND;
			end else begin
				o.freed_bytes = lru_sizes[idx];
				held_bytes -= lru_sizes[idx];
				lru_keys.delete(idx);
				lru_sizes.delete(idx);
			end
		end
		default: begin
			// List from the least recent until both limits hold with the incoming entry
			released = '0;
			kept = lru_keys.size();
			cap_eff = (cap_now == '0) ? 1 : cap_now;
			while (kept > 0) begin
				if ((held_bytes - released + b) <= budget_now && (kept + 1) <= cap_eff)
					break;
				o.victim_valid = 1'b1;
				o.victim_key = lru_keys[kept-1];
				o.last = 1'b0;
				fresh = {fresh, o};
				released += lru_sizes[kept-1];
				kept--;
			end
			if (fresh.size() != 0) begin
				o = fresh[fresh.size()-1];
				o.last = 1'b1;
				fresh[fresh.size()-1] = o;
			end
		end
		endcase
		if (fresh.size() == 0)
			fresh = {fresh, o};
	endfunction

	// Append one row to the stimulus table
	function automatic void add_row(step_t s);
		plan = {plan, s};
	endfunction

	function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.cfg_idx = idx;
		s.cfg_val = val;
		return s;
	endfunction

	function automatic step_t run_step(op_t op, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] b);
		step_t s;
		s = '0;
		s.op = op;
		s.key = k;
		s.bytes = b;
		return s;
	endfunction

	// Single-result row whose outcome is plain from the operation alone
	function automatic step_t typed_step(op_t op, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] b,
			status_t st, logic [SIZE_W-1:0] fr);
		step_t s;
		s = run_step(op, k, b);
		s.typed = 1'b1;
		s.res.status = st;
		s.res.freed_bytes = fr;
		s.res.last = 1'b1;
		return s;
	endfunction

	// Mostly modest sizes, now and then any 36-bit value
	function automatic logic [SIZE_W-1:0] pick_size();
		if ($urandom_range(11) == 0)
			return {4'($urandom_range(15)), $urandom};
		return SIZE_W'($urandom_range(32'h0010_0000));
	endfunction

	// Hand one word to the block at a falling edge and record what it should cause
	task automatic issue(op_t op, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] b,
			logic typed, outcome_t typed_out);
		if (!steady) begin
			while ($urandom_range(99) < 29) begin
				start = 1'b0;
				@(negedge clk);
			end
		end
		start = 1'b1;
		operation = op;
		key = k;
		entry_bytes = b;
		do @(posedge clk); while (busy);
		track_word(op, k, b);
		if (typed)
			awaited = {awaited, typed_out};
		else
			foreach (fresh[i]) awaited = {awaited, fresh[i]};
		@(negedge clk);
	endtask

	// Drop start and wait until the block has gone quiet
	task automatic settle();
		start = 1'b0;
		while (awaited.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
		REG_BYTE_BUDGET: budget_now = val[BUDGET_W-1:0];
		REG_COUNT_CAP:   cap_now = val[CAP_W-1:0];
		default: ;
		endcase
	endtask

	// Check every result word against the oldest expectation
	always @(posedge clk) begin : watch_results
		outcome_t want;
		if (arst_n && result_valid) begin
			if (awaited.size() == 0) begin
				$error("result word with nothing expected: status %0d key %h", status, victim_key);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (victim_valid !== want.victim_valid) begin
					$error("victim_valid: expected %0d, got %0d", want.victim_valid, victim_valid);
					mismatches++;
				end
				if (victim_key !== want.victim_key) begin
					$error("victim_key: expected %h, got %h", want.victim_key, victim_key);
					mismatches++;
				end
				if (freed_bytes !== want.freed_bytes) begin
					$error("freed_bytes: expected %h, got %h", want.freed_bytes, freed_bytes);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		op_t op;
		logic [KEY_W-1:0] k;
		logic fill;
		int roll;
		int waited;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_TOUCH;
		key = '0;
		entry_bytes = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BYTE_BUDGET;
		cfg_data = '0;
		mismatches = 0;
		steady = 1'b0;
		held_bytes = '0;
		budget_now = BUDGET_RESET;
		cap_now = CAP_RESET;

		key_pool[0] = KEY_ZERO;
		key_pool[1] = KEY_SEQ;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};

		// Directed rows: empty store, extremes, duplicates, soft budget, cap edge cases
		add_row(typed_step(OP_TOUCH,  KEY_ZERO, '0, ST_NOT_FOUND, '0));
		add_row(typed_step(OP_REMOVE, KEY_ONES, '0, ST_NOT_FOUND, '0));
		add_row(typed_step(OP_QUERY,  KEY_ZERO, '0, ST_OK, '0));
		add_row(typed_step(OP_QUERY,  KEY_ONES, SIZE_MAX, ST_OK, '0));
		add_row(typed_step(OP_INSERT, KEY_ZERO, '0, ST_OK, '0));
		add_row(typed_step(OP_INSERT, KEY_ONES, SIZE_MAX, ST_OK, '0));
		add_row(typed_step(OP_INSERT, KEY_ONES, 36'd5, ST_DUPLICATE, '0));
		add_row(run_step(OP_INSERT, KEY_MIX, 36'h123));
		add_row(run_step(OP_INSERT, KEY_SEQ, 36'h8000));
		add_row(typed_step(OP_TOUCH,  KEY_ONES, '0, ST_OK, '0));
		add_row(run_step(OP_QUERY, KEY_MIX, '0));
		add_row(run_step(OP_QUERY, KEY_SEQ, SIZE_MAX));
		add_row(cfg_step(REG_BYTE_BUDGET, '1));
		add_row(run_step(OP_QUERY, KEY_ZERO, '0));
		add_row(cfg_step(REG_COUNT_CAP, '0));
		add_row(run_step(OP_QUERY, KEY_ONES, '0));
		add_row(cfg_step(REG_COUNT_CAP, '1));
		add_row(cfg_step(REG_UNUSED_A, 36'h000000001));
		add_row(cfg_step(REG_UNUSED_B, 36'hFFFFFFFFF));
		add_row(run_step(OP_QUERY, KEY_ZERO, '0));
		add_row(typed_step(OP_REMOVE, KEY_ONES, '0, ST_OK, SIZE_MAX));
		add_row(typed_step(OP_REMOVE, KEY_MIX, '0, ST_OK, 36'h123));
		add_row(typed_step(OP_REMOVE, KEY_MIX, '0, ST_NOT_FOUND, '0));
		add_row(typed_step(OP_TOUCH,  KEY_MIX, '0, ST_NOT_FOUND, '0));
		add_row(cfg_step(REG_BYTE_BUDGET, '0));
		add_row(run_step(OP_QUERY, KEY_SEQ, '0));
		add_row(run_step(OP_QUERY, KEY_ONES, 36'd1));
		add_row(cfg_step(REG_BYTE_BUDGET, BUDGET_RESET));
		add_row(cfg_step(REG_COUNT_CAP, CAP_RESET));

		// Hold reset, then release at a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].cfg_idx, plan[i].cfg_val);
			end else begin
				issue(plan[i].op, plan[i].key, plan[i].bytes, plan[i].typed, plan[i].res);
			end
		end

		// Random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			fill = (ph == 0 || ph == 4 || ph == 7);
			steady = (ph == 1);
			case (ph)
			0, 7: begin
				write_reg(REG_BYTE_BUDGET, BUDGET_RESET);
				write_reg(REG_COUNT_CAP, CAP_RESET);
			end
			1: begin
				write_reg(REG_BYTE_BUDGET, CFG_DATA_W'($urandom_range(32'h0400_0000, 32'h0010_0000)));
				write_reg(REG_COUNT_CAP, CFG_DATA_W'($urandom_range(64, 1)));
			end
			2: begin
				write_reg(REG_BYTE_BUDGET, '0);
				write_reg(REG_COUNT_CAP, CFG_DATA_W'(64));
			end
			3: begin
				write_reg(REG_BYTE_BUDGET, '1);
				write_reg(REG_COUNT_CAP, '0);
			end
			4: begin
				write_reg(REG_BYTE_BUDGET, '1);
				write_reg(REG_COUNT_CAP, '1);
			end
			5: begin
				write_reg(REG_BYTE_BUDGET, {4'($urandom_range(15)), $urandom});
				write_reg(REG_COUNT_CAP, CFG_DATA_W'($urandom_range(16, 2)));
			end
			default: begin
				write_reg(REG_BYTE_BUDGET, CFG_DATA_W'(32'h0001_0000));
				write_reg(REG_COUNT_CAP, CFG_DATA_W'(1));
			end
			endcase
			write_reg(ph[0] ? REG_UNUSED_B : REG_UNUSED_A, {4'($urandom_range(15)), $urandom});

			for (int n = 0; n < PHASE_WORDS; n++) begin
				roll = $urandom_range(99);
				if (fill)
					op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_TOUCH :
						(roll < 85) ? OP_REMOVE : OP_QUERY;
				else
					op = (roll < 25) ? OP_TOUCH : (roll < 55) ? OP_INSERT :
						(roll < 80) ? OP_REMOVE : OP_QUERY;
				// Fresh keys grow the store; pool keys hit existing entries
				if ((fill && op == OP_INSERT && $urandom_range(1) == 0) || $urandom_range(9) == 0)
					k = {$urandom, $urandom};
				else
					k = key_pool[$urandom_range(POOL_SIZE - 1)];
				issue(op, k, pick_size(), 1'b0, '0);
			end
		end

		// Drain, with a bound, then allow the block to finish rotating back
		start = 1'b0;
		steady = 1'b0;
		waited = 0;
		while ((awaited.size() != 0 || busy) && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (140) @(negedge clk);
		if (awaited.size() != 0) begin
			$error("%0d expected result words never arrived", awaited.size());
			mismatches++;
		end

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
